// ===== design/awt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awt_pkg
// Shared constants and types for the accelerate/decelerate time warp.
// ----------------------------------------------------------------------------
package awt_pkg;

  // Default number of fraction bits of every time and fraction value.
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic REG_ACCEL = 1'b0;
  localparam logic REG_DECEL = 1'b1;

  // Which segment of the rate curve a sample falls on.
  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_RISE,
    MODE_FLAT,
    MODE_FALL
  } mode_t;

endpackage

// ===== design/awt_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awt_sample_if
// Valid/ready channel that carries one raw time sample.
// ----------------------------------------------------------------------------
interface awt_sample_if
  import awt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] time_in;

  modport source (output valid, output time_in, input ready);
  modport sink (input valid, input time_in, output ready);
endinterface

// ===== design/awt_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awt_result_if
// Valid/ready channel that carries one warped time value.
// ----------------------------------------------------------------------------
interface awt_result_if
  import awt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [FRAC_BITS:0]   time_out;

  modport source (output valid, output time_out, input ready);
  modport sink (input valid, input time_out, output ready);
endinterface

// ===== design/awt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awt_cell
// One restoring division step: develops one quotient bit and hands the
// partial remainder, the shifting dividend/quotient word, the divisor and
// the side data to the next cell.
// ----------------------------------------------------------------------------
module awt_cell #(
  parameter int DW = 17,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] work_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] work_o,
  output logic [DW-1:0] den_o,
  output logic [SW-1:0] side_o
);

  logic          valid;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          take;
  logic [DW-1:0] rem_next;
  logic [QW-1:0] work_next;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial     = {rem_i, work_i[QW-1]};
    diff      = trial - {1'b0, den_i};
    take      = ~diff[DW];
    rem_next  = take ? diff[DW-1:0] : trial[DW-1:0];
    work_next = {work_i[QW-2:0], take};
  end

  assign up_ready = ~valid | dn_ready;
  assign dn_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_o  <= rem_next;
      work_o <= work_next;
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

// ===== design/awt_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awt_row
// A row of QW division cells; the quotient leaves in work_o after the last.
// ----------------------------------------------------------------------------
module awt_row #(
  parameter int DW = 17,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] work_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [QW-1:0] work_o,
  output logic [SW-1:0] side_o
);

  logic          v    [QW+1];
  logic          r    [QW+1];
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] work [QW+1];
  logic [DW-1:0] den  [QW+1];
  logic [SW-1:0] side [QW+1];

  assign v[0]     = up_valid;
  assign up_ready = r[0];
  assign rem[0]   = rem_i;
  assign work[0]  = work_i;
  assign den[0]   = den_i;
  assign side[0]  = side_i;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    awt_cell #(
      .DW(DW),
      .QW(QW),
      .SW(SW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(v[i]),
      .up_ready(r[i]),
      .rem_i   (rem[i]),
      .work_i  (work[i]),
      .den_i   (den[i]),
      .side_i  (side[i]),
      .dn_valid(v[i+1]),
      .dn_ready(r[i+1]),
      .rem_o   (rem[i+1]),
      .work_o  (work[i+1]),
      .den_o   (den[i+1]),
      .side_o  (side[i+1])
    );
  end

  // The final remainder and divisor are not needed downstream.
  assign dn_valid = v[QW];
  assign r[QW]    = dn_ready;
  assign work_o   = work[QW];
  assign side_o   = side[QW];

  logic unused_tail;
  assign unused_tail = ^{rem[QW], den[QW]};

endmodule

// ===== design/accel_decel_time_warp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_decel_time_warp
// Clamps a time sample to 0..1 and maps it through the accelerate/decelerate
// curve: the normalized integral of a trapezoidal rate profile.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake            payload
//   sample    in   valid/ready          time_in   signed Q2.F
//   result    out  valid/ready          time_out  unsigned Q1.F, at most 1.0
//   cfg       in   cfg_we (write only)  cfg_index, cfg_wdata
//
// One request enters per cycle while the stages are not held by a stalled result.
// A request passes stage A, stage B, the two rows of division cells with
// stage C between them, and the output register, one quotient bit per cell:
// FRAC_BITS+1 cells for the ramp quotient, FRAC_BITS+2 for normalization by c.
// Reset clears every stage valid bit and both fraction registers.
// Every stage holds its request only while its successor is full and held,
// so a stalled result does not keep earlier stages from filling bubbles.
// ----------------------------------------------------------------------------
module accel_decel_time_warp
  import awt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [FRAC_BITS:0] cfg_wdata,
  awt_sample_if.sink         sample,
  awt_result_if.source       result
);

  localparam int F    = FRAC_BITS;
  localparam int W1   = F + 1;          // time and fraction width
  localparam int W2   = F + 2;          // doubled sum and c width
  localparam int WX   = F + 4;          // headroom for the sum arithmetic
  localparam int SW1  = 4 * W1 + 2 + W2;
  localparam int SW2  = W1 + 1;
  localparam int STAGES = 2 + W1 + 1 + W2 + 1;
  localparam int OCC_W  = $clog2(STAGES + 1);

  localparam logic [W1-1:0] ONE     = {1'b1, {F{1'b0}}};
  localparam logic [W2-1:0] TWO_ONE = {1'b1, {(F+1){1'b0}}};

  // Configuration registers.
  logic [W1-1:0] accel;
  logic [W1-1:0] decel;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel <= '0;
      decel <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL: accel <= cfg_wdata;
        REG_DECEL: decel <= cfg_wdata;
      endcase
    end
  end

  // Stage A: clamp the sample and classify it against the rate curve.
  // The user must not change the fraction registers while a request is in
  // flight; not enforced here. They are sampled and carried with the request.
  logic [W1-1:0] t;
  logic [W2-1:0] sum_ad;
  logic [W2-1:0] td;
  logic [W1-1:0] r_full;
  mode_t         mode;

  always_comb begin
    if (sample.time_in[F+1]) begin
      t = '0;
    end else if (sample.time_in[F:0] > ONE) begin
      t = ONE;
    end else begin
      t = sample.time_in[F:0];
    end
    sum_ad = {1'b0, accel} + {1'b0, decel};
    td     = {1'b0, t} + {1'b0, decel};
    r_full = W1'(td - {1'b0, ONE});
    // Both fractions zero, or more than one between them, means identity.
    if ((accel == '0 && decel == '0) || sum_ad > {1'b0, ONE}) begin
      mode = MODE_PASS;
    end else if (t < accel) begin
      mode = MODE_RISE;
    end else if (td <= {1'b0, ONE}) begin
      mode = MODE_FLAT;
    end else begin
      mode = MODE_FALL;
    end
  end

  logic          a_valid, a_ready;
  logic [W1-1:0] a_t, a_acc, a_dec, a_r, a_x;
  logic [W2-1:0] a_c2;
  mode_t         a_mode;

  logic          b_valid, b_ready;
  logic [W1-1:0] b_t, b_acc, b_dec, b_r;
  logic [W2-1:0] b_c2;
  mode_t         b_mode;
  logic [2*W1-1:0] b_prod;

  logic          row1_ready;

  assign b_ready      = ~b_valid | row1_ready;
  assign a_ready      = ~a_valid | b_ready;
  assign sample.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && sample.valid) begin
      a_t    <= t;
      a_acc  <= accel;
      a_dec  <= decel;
      a_r    <= r_full;
      a_c2   <= TWO_ONE - sum_ad;
      a_mode <= mode;
      a_x    <= (mode == MODE_RISE) ? t : r_full;
    end
  end

  // Stage B: square of the time into the ramp (t on the way up, r on the
  // way down).
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_t    <= a_t;
      b_acc  <= a_acc;
      b_dec  <= a_dec;
      b_r    <= a_r;
      b_c2   <= a_c2;
      b_mode <= a_mode;
      b_prod <= (2*W1)'(a_x) * (2*W1)'(a_x);
    end
  end

  // First row: the ramp quotient, square divided by a or by d. The high
  // part of the square is always below the divisor on the ramps, so
  // W1 quotient bits suffice. On the other segments the quotient is unused.
  logic [W1-1:0]  den1;
  logic [W1-1:0]  row1_q;
  logic [SW1-1:0] row1_side;
  logic           row1_valid;
  logic           c_ready;

  assign den1 = (b_mode == MODE_RISE) ? b_acc : b_dec;

  awt_row #(
    .DW(W1),
    .QW(W1),
    .SW(SW1)
  ) u_row_ramp (
    .clk     (clk),
    .rst     (rst),
    .up_valid(b_valid),
    .up_ready(row1_ready),
    .rem_i   ({1'b0, b_prod[2*W1-2:W1]}),
    .work_i  (b_prod[W1-1:0]),
    .den_i   (den1),
    .side_i  ({b_t, b_mode, b_acc, b_dec, b_r, b_c2}),
    .dn_valid(row1_valid),
    .dn_ready(c_ready),
    .work_o  (row1_q),
    .side_o  (row1_side)
  );

  logic unused_prod_msb;
  assign unused_prod_msb = b_prod[2*W1-1];

  // Stage C: the doubled sum of the integral on each segment.
  logic [W1-1:0] s1_t, s1_acc, s1_dec, s1_r;
  logic [W2-1:0] s1_c2;
  mode_t         s1_mode;
  logic [WX-1:0] s2w;

  always_comb begin
    s1_t    = row1_side[SW1-1 -: W1];
    s1_mode = mode_t'(row1_side[SW1-W1-1 -: 2]);
    s1_acc  = row1_side[SW1-W1-3 -: W1];
    s1_dec  = row1_side[SW1-2*W1-3 -: W1];
    s1_r    = row1_side[SW1-3*W1-3 -: W1];
    s1_c2   = row1_side[W2-1:0];
    case (s1_mode)
      MODE_RISE: s2w = WX'(row1_q);
      MODE_FLAT: s2w = WX'({s1_t, 1'b0}) - WX'(s1_acc);
      // a + 2(1 - a - d) + 2r - r*r/d, regrouped.
      MODE_FALL: s2w = WX'(TWO_ONE) - WX'(s1_acc) - WX'({s1_dec, 1'b0})
                       + WX'({s1_r, 1'b0}) - WX'(row1_q);
      default:   s2w = '0;
    endcase
  end

  logic          c_valid;
  logic [W1-1:0] c_t;
  logic          c_pass;
  logic [W2-1:0] c_s2, c_c2;
  logic          row2_ready;

  assign c_ready = ~c_valid | row2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= row1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && row1_valid) begin
      c_t    <= s1_t;
      c_pass <= (s1_mode == MODE_PASS);
      c_s2   <= s2w[W2-1:0];
      c_c2   <= s1_c2;
    end
  end

  // Second row: (S2 << F) / c2. The sum never exceeds c2, so the high
  // part S2 >> 2 is below the divisor and the quotient is at most 1.0.
  logic [W2-1:0]  row2_q;
  logic [SW2-1:0] row2_side;
  logic           row2_valid;
  logic           o_ready;

  awt_row #(
    .DW(W2),
    .QW(W2),
    .SW(SW2)
  ) u_row_norm (
    .clk     (clk),
    .rst     (rst),
    .up_valid(c_valid),
    .up_ready(row2_ready),
    .rem_i   ({2'b00, c_s2[W2-1:2]}),
    .work_i  ({c_s2[1:0], {F{1'b0}}}),
    .den_i   (c_c2),
    .side_i  ({c_t, c_pass}),
    .dn_valid(row2_valid),
    .dn_ready(o_ready),
    .work_o  (row2_q),
    .side_o  (row2_side)
  );

  // Output register: pass-through or the saturated quotient.
  logic          o_valid;
  logic [W1-1:0] o_time;
  logic [W1-1:0] o_time_next;

  always_comb begin
    if (row2_side[0]) begin
      o_time_next = row2_side[SW2-1:1];
    end else if (row2_q > {1'b0, ONE}) begin
      o_time_next = ONE;
    end else begin
      o_time_next = row2_q[W1-1:0];
    end
  end

  assign o_ready = ~o_valid | result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_ready) begin
      o_valid <= row2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && row2_valid) begin
      o_time <= o_time_next;
    end
  end

  assign result.valid    = o_valid;
  assign result.time_out = o_time;

  // Requests in flight, for the checks below.
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;

  always_comb begin
    occ_next = occ;
    if (sample.valid && sample.ready) begin
      occ_next = occ_next + OCC_W'(1);
    end
    if (result.valid && result.ready) begin
      occ_next = occ_next - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  // The pipeline never holds more requests than it has stages.
  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(STAGES))
    else $error("more requests in flight than pipeline stages");

  // A result can only be shown if some request is in flight.
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    (occ == '0) |-> !result.valid)
    else $error("result valid with an empty pipeline");

  // With the sink taking results, every stage can move, so input is open.
  a_ready_chain : assert property (@(posedge clk) disable iff (rst)
    result.ready |-> sample.ready)
    else $error("input stalled while the result side is ready");

  // The warped time never exceeds 1.0.
  a_out_range : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.time_out <= ONE))
    else $error("result above one");

  // Nothing comes out in the cycle right after reset.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule
